// ----- hdl/vha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vha_pkg
// Shared types, codes and helpers of the voxel histogram accumulator.
// ----------------------------------------------------------------------------
package vha_pkg;

   localparam int BINS_X_DEFAULT = 16;
   localparam int BINS_Y_DEFAULT = 16;
   localparam int BINS_Z_DEFAULT = 16;

   localparam int COORD_W  = 32;
   localparam int BIN_W    = 48;
   localparam int COUNT_W  = 32;
   localparam int LANDED_W = 7;
   localparam int POS_W    = 41;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_ADD     = 2'd0;
   localparam opcode_type OP_ADD_SUB = 2'd1;
   localparam opcode_type OP_PREDICT = 2'd2;
   localparam opcode_type OP_NONE    = 2'd3;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_LOWER_X = 3'd0;
   localparam csr_index_type CSR_LOWER_Y = 3'd1;
   localparam csr_index_type CSR_LOWER_Z = 3'd2;
   localparam csr_index_type CSR_SCALE_X = 3'd3;
   localparam csr_index_type CSR_SCALE_Y = 3'd4;
   localparam csr_index_type CSR_SCALE_Z = 3'd5;
   localparam csr_index_type CSR_SUBDIV  = 3'd6;

   localparam logic [1:0]  SUB_LOG2_MAX  = 2'd2;
   localparam logic [31:0] SCALE_RESET   = 32'h0001_0000;
   localparam logic signed [BIN_W-1:0] BIN_MAX = {1'b0, {(BIN_W-1){1'b1}}};
   localparam logic signed [BIN_W-1:0] BIN_MIN = {1'b1, {(BIN_W-1){1'b0}}};

   typedef struct packed {
      opcode_type                 opcode;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic signed [COORD_W-1:0]  coord_z;
      logic signed [COORD_W-1:0]  weight;
   } req_type;

   typedef struct packed {
      logic                       accepted;
      logic [LANDED_W-1:0]        landed_points;
      logic signed [BIN_W-1:0]    bin_value;
      logic [COUNT_W-1:0]         total_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] lower_x;
      logic [31:0] lower_y;
      logic [31:0] lower_z;
      logic [31:0] scale_x;
      logic [31:0] scale_y;
      logic [31:0] scale_z;
      logic [1:0]  subdivide_log2;
   } cfg_type;

   // sub-point offset (2t+1-s) * 2^(31-lvl), in Q.32 bins
   function automatic logic signed [31:0] sub_offset(input logic [1:0] t,
                                                     input logic [1:0] lvl);
      logic signed [3:0] num;
      num = $signed({1'b0, t, 1'b1}) - $signed(4'd1 << lvl);
      return 32'(num) <<< (5'd31 - 5'(lvl));
   endfunction

endpackage

// ----- hdl/vha_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vha_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vha_ram #(
   parameter int WIDTH  = vha_pkg::BIN_W,
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/vha_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vha_csr
// Configuration register file: grid bounds, scales and subdivision level.
// ----------------------------------------------------------------------------
module vha_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  vha_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data,
   output vha_pkg::cfg_type       cfg
);
   import vha_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LOWER_X: cfg_in.lower_x = csr_data;
            CSR_LOWER_Y: cfg_in.lower_y = csr_data;
            CSR_LOWER_Z: cfg_in.lower_z = csr_data;
            CSR_SCALE_X: cfg_in.scale_x = csr_data;
            CSR_SCALE_Y: cfg_in.scale_y = csr_data;
            CSR_SCALE_Z: cfg_in.scale_z = csr_data;
            CSR_SUBDIV:  cfg_in.subdivide_log2 = csr_data[1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_x        <= '0;
         cfg_ff.lower_y        <= '0;
         cfg_ff.lower_z        <= '0;
         cfg_ff.scale_x        <= SCALE_RESET;
         cfg_ff.scale_y        <= SCALE_RESET;
         cfg_ff.scale_z        <= SCALE_RESET;
         cfg_ff.subdivide_log2 <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;
endmodule

// ----- hdl/vha_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vha_axis
// One axis: registered bin position |coord - lower| * scale, then offset,
// range check and bin index.
// ----------------------------------------------------------------------------
module vha_axis #(
   parameter int NB    = vha_pkg::BINS_X_DEFAULT,
   parameter int IDX_W = (NB > 1) ? $clog2(NB) : 1
) (
   input  logic                clock,
   input  logic                load,
   input  logic signed [31:0]  coord,
   input  logic [31:0]         lower,
   input  logic [31:0]         scale,
   input  logic signed [31:0]  offset,
   output logic                hit,
   output logic [IDX_W-1:0]    idx
);
   import vha_pkg::*;

   logic signed [32:0]       diff;
   logic [32:0]              mag;
   logic [63:0]              mult;
   logic [64:0]              prod;
   logic signed [POS_W-1:0]  pos;
   logic signed [POS_W-1:0]  q;
   logic [8:0]               q_hi;

   logic        neg_ff,  neg_in;
   logic        far_ff,  far_in;
   logic [38:0] pmag_ff, pmag_in;

   assign diff = 33'(coord) - 33'($signed(lower));
   assign mag  = diff[32] ? 33'(-diff) : 33'(diff);
   assign mult = mag[31:0] * scale;
   // magnitude 2^32 only occurs with a zero low word
   assign prod = mag[32] ? {1'b0, scale, 32'd0} : {1'b0, mult};

   always_comb begin
      neg_in  = neg_ff;
      far_in  = far_ff;
      pmag_in = pmag_ff;
      if (load) begin
         neg_in  = diff[32];
         far_in  = |prod[64:39];
         pmag_in = prod[38:0];
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      far_ff  <= far_in;
      pmag_ff <= pmag_in;
   end

   assign pos  = neg_ff ? -$signed({2'b00, pmag_ff}) : $signed({2'b00, pmag_ff});
   assign q    = pos + POS_W'(offset);
   assign q_hi = q[40:32];

   always_comb begin
      hit = 1'b0;
      idx = '0;
      if (!far_ff) begin
         if (q[40]) begin
            // less than one bin below the bound still lands in bin 0
            hit = (&q_hi) && (|q[31:0]);
         end else begin
            hit = q_hi < 9'(NB);
            idx = IDX_W'(q_hi);
         end
      end
   end
endmodule

// ----- hdl/voxel_histogram_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_histogram_accumulator
// Weighted 3D point binning into a saturating voxel grid held in one RAM.
// ----------------------------------------------------------------------------
// Each item walks n sub-points, n = 1 for add and predict and n = s^3
//   (1, 8 or 64) for a subdivided add; the result is registered once they drain.
// Throughput: one sub-point per cycle walks the read-modify-write path of the
//   bin RAM; a new item is taken only after the last one's result is registered.
// Reset: a clearing pass zeroes all BINS_X*BINS_Y*BINS_Z bins (4096 by default);
//   no item is taken meanwhile, csr writes are.
module voxel_histogram_accumulator #(
   parameter int BINS_X = vha_pkg::BINS_X_DEFAULT,
   parameter int BINS_Y = vha_pkg::BINS_Y_DEFAULT,
   parameter int BINS_Z = vha_pkg::BINS_Z_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vha_pkg::req_type       req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vha_pkg::rsp_type       rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  vha_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data
);
   import vha_pkg::*;

   localparam int NBINS  = BINS_X * BINS_Y * BINS_Z;
   localparam int ADDR_W = (NBINS > 1) ? $clog2(NBINS) : 1;
   localparam int XI_W   = (BINS_X > 1) ? $clog2(BINS_X) : 1;
   localparam int YI_W   = (BINS_Y > 1) ? $clog2(BINS_Y) : 1;
   localparam int ZI_W   = (BINS_Z > 1) ? $clog2(BINS_Z) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NBINS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   cfg_type cfg;

   logic              accept;
   logic              finish;
   logic [1:0]        lvl_cfg;
   logic [1:0]        lvl_acc;
   logic [2:0]        w_shift;
   logic [2:0]        cnt_shift;
   logic [1:0]        dmask;
   logic [1:0]        dx, dy, dz;
   logic [5:0]        last_cnt;
   logic              ok_x, ok_y, ok_z;
   logic [XI_W-1:0]   ix;
   logic [YI_W-1:0]   iy;
   logic [ZI_W-1:0]   iz;
   logic [ADDR_W-1:0] flat;
   logic              walk_hit;
   logic              b_write;
   logic              b_pred;
   logic signed [BIN_W-1:0] rd_data;
   logic signed [BIN_W-1:0] cur;
   logic signed [BIN_W:0]   sum;
   logic signed [BIN_W-1:0] sat;
   logic [COUNT_W:0]        csum;
   logic [COUNT_W-1:0]      count_nx;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [BIN_W-1:0]  ram_wr_data;

   // control
   logic [1:0]        state_ff,      state_in;
   logic              clear_ff,      clear_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic              a_busy_ff,     a_busy_in;
   logic              b_busy_ff,     b_busy_in;
   logic              lw_valid_ff,   lw_valid_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   logic [COUNT_W-1:0] count_ff,     count_in;
   // item and pipeline payload
   opcode_type        op_ff,         op_in;
   logic [1:0]        lvl_ff,        lvl_in;
   logic signed [31:0] w_ff,         w_in;
   logic [5:0]        cnt_ff,        cnt_in;
   logic [LANDED_W-1:0] landed_ff,   landed_in;
   logic              pred_hit_ff,   pred_hit_in;
   logic signed [BIN_W-1:0] pred_val_ff, pred_val_in;
   logic              a_hit_ff,      a_hit_in;
   logic [ADDR_W-1:0] a_addr_ff,     a_addr_in;
   logic              b_hit_ff,      b_hit_in;
   logic [ADDR_W-1:0] b_addr_ff,     b_addr_in;
   logic [ADDR_W-1:0] lw_addr_ff,    lw_addr_in;
   logic signed [BIN_W-1:0] lw_data_ff, lw_data_in;
   rsp_type           rsp_ff,        rsp_in;

   vha_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req_ready = (state_ff == ST_IDLE) && !clear_ff;
   assign accept    = req_valid && req_ready;

   assign lvl_cfg = (cfg.subdivide_log2 > SUB_LOG2_MAX) ? SUB_LOG2_MAX : cfg.subdivide_log2;
   assign lvl_acc = (req_payload.opcode == OP_ADD_SUB) ? lvl_cfg : 2'd0;
   assign w_shift = {lvl_acc, 1'b0} + {1'b0, lvl_acc};

   // sub-point digits, z fastest
   assign cnt_shift = {lvl_ff, 1'b0} + {1'b0, lvl_ff};
   assign dmask     = 2'((3'd1 << lvl_ff) - 3'd1);
   assign dz        = cnt_ff[1:0] & dmask;
   assign dy        = 2'(cnt_ff >> lvl_ff) & dmask;
   assign dx        = 2'(cnt_ff >> {lvl_ff, 1'b0}) & dmask;
   assign last_cnt  = 6'((7'd1 << cnt_shift) - 7'd1);

   vha_axis #(.NB(BINS_X)) u_axis_x (
      .clock  (clock),
      .load   (accept),
      .coord  (req_payload.coord_x),
      .lower  (cfg.lower_x),
      .scale  (cfg.scale_x),
      .offset (sub_offset(dx, lvl_ff)),
      .hit    (ok_x),
      .idx    (ix)
   );

   vha_axis #(.NB(BINS_Y)) u_axis_y (
      .clock  (clock),
      .load   (accept),
      .coord  (req_payload.coord_y),
      .lower  (cfg.lower_y),
      .scale  (cfg.scale_y),
      .offset (sub_offset(dy, lvl_ff)),
      .hit    (ok_y),
      .idx    (iy)
   );

   vha_axis #(.NB(BINS_Z)) u_axis_z (
      .clock  (clock),
      .load   (accept),
      .coord  (req_payload.coord_z),
      .lower  (cfg.lower_z),
      .scale  (cfg.scale_z),
      .offset (sub_offset(dz, lvl_ff)),
      .hit    (ok_z),
      .idx    (iz)
   );

   assign flat = ADDR_W'(ix) + ADDR_W'(BINS_X) *
                 (ADDR_W'(iy) + ADDR_W'(BINS_Y) * ADDR_W'(iz));
   assign walk_hit = (state_ff == ST_WALK) && ok_x && ok_y && ok_z && (op_ff != OP_NONE);

   // read stage is a_*, modify/write stage is b_*; last write forwarded
   assign cur = (lw_valid_ff && (lw_addr_ff == b_addr_ff)) ? lw_data_ff : rd_data;
   assign sum = (BIN_W+1)'(cur) + (BIN_W+1)'(w_ff);
   assign sat = (sum[BIN_W] != sum[BIN_W-1]) ? (sum[BIN_W] ? BIN_MIN : BIN_MAX)
                                              : sum[BIN_W-1:0];
   assign b_write = b_busy_ff && b_hit_ff && (op_ff != OP_PREDICT);
   assign b_pred  = b_busy_ff && b_hit_ff && (op_ff == OP_PREDICT);

   assign ram_wr_en   = clear_ff || b_write;
   assign ram_wr_addr = clear_ff ? clear_addr_ff : b_addr_ff;
   assign ram_wr_data = clear_ff ? '0 : sat;

   vha_ram #(.WIDTH(BIN_W), .DEPTH(NBINS)) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (a_addr_ff),
      .rd_data (rd_data)
   );

   assign finish   = (state_ff == ST_DRAIN) && !a_busy_ff && !b_busy_ff &&
                     (!rsp_valid_ff || rsp_ready);
   assign csum     = {1'b0, count_ff} + (COUNT_W+1)'(landed_ff);
   assign count_nx = csum[COUNT_W] ? '1 : csum[COUNT_W-1:0];

   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      op_in         = op_ff;
      lvl_in        = lvl_ff;
      w_in          = w_ff;
      cnt_in        = cnt_ff;
      landed_in     = landed_ff;
      pred_hit_in   = pred_hit_ff;
      pred_val_in   = pred_val_ff;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + ADDR_W'(1);
         clear_in      = (clear_addr_ff != LAST_ADDR);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_WALK;
               op_in       = req_payload.opcode;
               lvl_in      = lvl_acc;
               w_in        = req_payload.weight >>> w_shift;
               cnt_in      = '0;
               landed_in   = '0;
               pred_hit_in = 1'b0;
            end
         end
         ST_WALK: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == last_cnt) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (b_write) begin
         landed_in = landed_ff + LANDED_W'(1);
      end
      if (b_pred) begin
         pred_hit_in = 1'b1;
         pred_val_in = cur;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         count_in               = count_nx;
         rsp_valid_in           = 1'b1;
         rsp_in.accepted        = (op_ff == OP_PREDICT) ? pred_hit_ff : (landed_ff != '0);
         rsp_in.landed_points   = landed_ff;
         rsp_in.bin_value       = pred_hit_ff ? pred_val_ff : '0;
         rsp_in.total_count     = count_nx;
      end
   end

   assign a_busy_in   = (state_ff == ST_WALK);
   assign a_hit_in    = walk_hit;
   assign a_addr_in   = flat;
   assign b_busy_in   = a_busy_ff;
   assign b_hit_in    = a_hit_ff;
   assign b_addr_in   = a_addr_ff;
   assign lw_valid_in = b_write;
   assign lw_addr_in  = b_addr_ff;
   assign lw_data_in  = sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         a_busy_ff     <= 1'b0;
         b_busy_ff     <= 1'b0;
         lw_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         a_busy_ff     <= a_busy_in;
         b_busy_ff     <= b_busy_in;
         lw_valid_ff   <= lw_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      lvl_ff      <= lvl_in;
      w_ff        <= w_in;
      cnt_ff      <= cnt_in;
      landed_ff   <= landed_in;
      pred_hit_ff <= pred_hit_in;
      pred_val_ff <= pred_val_in;
      a_hit_ff    <= a_hit_in;
      a_addr_ff   <= a_addr_in;
      b_hit_ff    <= b_hit_in;
      b_addr_ff   <= b_addr_in;
      lw_addr_ff  <= lw_addr_in;
      lw_data_ff  <= lw_data_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (state_ff == ST_IDLE) && !a_busy_ff && !b_busy_ff)
      else $error("bin pipeline active during clearing pass");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !a_busy_ff && !b_busy_ff)
      else $error("input taken with sub-points still in flight");

   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      b_busy_ff |-> $past(a_busy_ff))
      else $error("write stage busy without a read the cycle before");

   a_landed_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (landed_ff <= 7'd64))
      else $error("more landed sub-points than exist");

   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished item did not reach the result register");
`endif
endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for voxel_histogram_accumulator. A local model of the
// bin grid and the point counter predicts every result. The bench runs
// directed grid-edge and subdivision cases, repeated extreme weights, a long
// receiver stall, and random points under several register settings, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import vha_pkg::*;

   localparam int BX    = BINS_X_DEFAULT;
   localparam int BY    = BINS_Y_DEFAULT;
   localparam int BZ    = BINS_Z_DEFAULT;
   localparam int LIMIT = 5_000_000;
   localparam int DRAIN = 80;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_LOWER_X;
   logic [31:0]   csr_data = '0;

   // model state
   longint        grid [BX*BY*BZ];
   logic [31:0]   points_seen;
   cfg_type       model_cfg;
   rsp_type       due_rsp [$];

   int            err_count = 0;
   int            cycle_count = 0;
   int            hold_off = 0;
   bit            idle_en = 1'b0;

   voxel_histogram_accumulator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   function automatic bit axis_bin(input logic signed [31:0] coord,
                                   input logic [31:0] lower,
                                   input logic [31:0] scale,
                                   input longint off, input int nb,
                                   output int idx);
      longint      diff, p, q;
      logic [63:0] mag, prod;
      idx = 0;
      diff = longint'(coord) - longint'($signed(lower));
      mag = 64'((diff < 0) ? -diff : diff);
      prod = mag * {32'd0, scale};
      if ((prod >> 32) >= 128)
         return 1'b0;
      p = (diff < 0) ? -longint'(prod) : longint'(prod);
      q = p + off;
      if (q < 0)
         return (-q) < (longint'(1) <<< 32);
      if ((q >>> 32) >= nb)
         return 1'b0;
      idx = int'(q >>> 32);
      return 1'b1;
   endfunction

   function automatic bit locate(input req_type r, input longint ox,
                                 input longint oy, input longint oz,
                                 output int flat);
      int ix, iy, iz;
      flat = 0;
      if (!axis_bin(r.coord_x, model_cfg.lower_x, model_cfg.scale_x, ox, BX, ix))
         return 1'b0;
      if (!axis_bin(r.coord_y, model_cfg.lower_y, model_cfg.scale_y, oy, BY, iy))
         return 1'b0;
      if (!axis_bin(r.coord_z, model_cfg.lower_z, model_cfg.scale_z, oz, BZ, iz))
         return 1'b0;
      flat = ix + BX * (iy + BY * iz);
      return 1'b1;
   endfunction

   function automatic void grid_add(input int f, input longint w);
      longint s;
      s = grid[f] + w;
      if (s > longint'(BIN_MAX))
         s = longint'(BIN_MAX);
      if (s < longint'(BIN_MIN))
         s = longint'(BIN_MIN);
      grid[f] = s;
   endfunction

   // updates the grid model and returns the result the item must produce
   function automatic rsp_type apply_point(input req_type r);
      rsp_type     e;
      longint      w, sub_w, step, tot;
      int          flat, lvl, n;
      int unsigned landed;
      e = '0;
      landed = 0;
      w = longint'(r.weight);
      case (r.opcode)
         OP_ADD: begin
            if (locate(r, 0, 0, 0, flat)) begin
               grid_add(flat, w);
               landed = 1;
            end
         end
         OP_ADD_SUB: begin
            lvl = (model_cfg.subdivide_log2 > SUB_LOG2_MAX) ? SUB_LOG2_MAX
                                                            : model_cfg.subdivide_log2;
            n = 1 << lvl;
            step = longint'(1) <<< (31 - lvl);
            sub_w = w >>> (3 * lvl);
            for (int a = 0; a < n; a++)
               for (int b = 0; b < n; b++)
                  for (int d = 0; d < n; d++)
                     if (locate(r, (2*a+1-n)*step, (2*b+1-n)*step, (2*d+1-n)*step,
                                flat)) begin
                        grid_add(flat, sub_w);
                        landed++;
                     end
         end
         OP_PREDICT: begin
            if (locate(r, 0, 0, 0, flat)) begin
               e.accepted = 1'b1;
               e.bin_value = 48'(grid[flat]);
            end
         end
         default: ;
      endcase
      if (r.opcode == OP_ADD || r.opcode == OP_ADD_SUB) begin
         tot = longint'(points_seen) + landed;
         points_seen = (tot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(tot);
         e.accepted = (landed != 0);
      end
      e.landed_points = 7'(landed);
      e.total_count = points_seen;
      return e;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 15) == 0)
         return $urandom_range(8, 60);
      return $urandom_range(0, 3);
   endfunction

   function automatic req_type point(input opcode_type op, input logic [31:0] x,
                                     input logic [31:0] y, input logic [31:0] z,
                                     input logic [31:0] w);
      req_type r;
      r.opcode = op;
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      r.weight = w;
      return r;
   endfunction

   // mostly lands within an eighth of the grid extent around the grid
   function automatic logic [31:0] coord_near_grid(input logic [31:0] lower,
                                                   input logic [31:0] scale,
                                                   input int nb);
      longint      ext, c;
      logic [63:0] r;
      if (scale == 0 || $urandom_range(0, 7) == 0)
         return $urandom;
      ext = (longint'(nb) <<< 32) / longint'(scale);
      if (ext > (longint'(1) <<< 31))
         ext = longint'(1) <<< 31;
      if (ext < 8)
         ext = 8;
      r = {$urandom, $urandom};
      c = longint'($signed(lower)) - ext / 8 + longint'(r % 64'(ext + ext / 4));
      if (c > 64'sd2147483647)
         c = 64'sd2147483647;
      if (c < -64'sd2147483648)
         c = -64'sd2147483648;
      return c[31:0];
   endfunction

   function automatic req_type random_item();
      req_type     r;
      int unsigned v;
      v = $urandom_range(0, 19);
      r.opcode = (v < 7) ? OP_ADD : (v < 13) ? OP_ADD_SUB : (v < 19) ? OP_PREDICT : OP_NONE;
      r.coord_x = coord_near_grid(model_cfg.lower_x, model_cfg.scale_x, BX);
      r.coord_y = coord_near_grid(model_cfg.lower_y, model_cfg.scale_y, BY);
      r.coord_z = coord_near_grid(model_cfg.lower_z, model_cfg.scale_z, BZ);
      r.weight = $urandom_range(0, 1) ? 32'($urandom)
                                      : 32'($urandom_range(0, 32'h40000)) - 32'h20000;
      return r;
   endfunction

   function automatic cfg_type default_cfg();
      cfg_type c;
      c = '0;
      c.scale_x = SCALE_RESET;
      c.scale_y = SCALE_RESET;
      c.scale_z = SCALE_RESET;
      return c;
   endfunction

   function automatic logic [31:0] pick_lower();
      case ($urandom_range(0, 4))
         0: return 32'h0;
         1: return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
         2: return $urandom;
         3: return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 6))
         0: return SCALE_RESET;
         1: return 32'h0000_8000;
         2: return 32'h0004_0000;
         3: return $urandom_range(32'h1000, 32'h10_0000);
         4: return 32'h0;
         5: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic cfg_type phase_cfg(input int ph);
      cfg_type c;
      case (ph)
         0: begin
            c.lower_x = 32'h8000_0000;
            c.lower_y = 32'h8000_0000;
            c.lower_z = 32'h8000_0000;
            c.scale_x = 32'hFFFF_FFFF;
            c.scale_y = 32'hFFFF_FFFF;
            c.scale_z = 32'hFFFF_FFFF;
            c.subdivide_log2 = 2'd2;
         end
         1: begin
            c.lower_x = 32'h7FFF_FFFF;
            c.lower_y = 32'h7FFF_FFFF;
            c.lower_z = 32'h7FFF_FFFF;
            c.scale_x = 32'h0;
            c.scale_y = 32'h0;
            c.scale_z = 32'h0;
            c.subdivide_log2 = 2'd3;
         end
         default: begin
            c.lower_x = pick_lower();
            c.lower_y = pick_lower();
            c.lower_z = pick_lower();
            c.scale_x = pick_scale();
            c.scale_y = pick_scale();
            c.scale_z = pick_scale();
            c.subdivide_log2 = 2'($urandom_range(0, 3));
         end
      endcase
      return c;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      req_payload <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      due_rsp.push_back(apply_point(item));
      gap = idle_en ? gap_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LOWER_X: model_cfg.lower_x = data;
         CSR_LOWER_Y: model_cfg.lower_y = data;
         CSR_LOWER_Z: model_cfg.lower_z = data;
         CSR_SCALE_X: model_cfg.scale_x = data;
         CSR_SCALE_Y: model_cfg.scale_y = data;
         CSR_SCALE_Z: model_cfg.scale_z = data;
         CSR_SUBDIV:  model_cfg.subdivide_log2 = data[1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input cfg_type c);
      write_reg(CSR_LOWER_X, c.lower_x);
      write_reg(CSR_LOWER_Y, c.lower_y);
      write_reg(CSR_LOWER_Z, c.lower_z);
      write_reg(CSR_SCALE_X, c.scale_x);
      write_reg(CSR_SCALE_Y, c.scale_y);
      write_reg(CSR_SCALE_Z, c.scale_z);
      write_reg(CSR_SUBDIV, 32'(c.subdivide_log2));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // unit grid from 0.0 to 16.0 on every axis
   task automatic test_directed_grid();
      idle_en = 1'b1;
      configure(default_cfg());
      send_item(point(OP_ADD, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000));
      send_item(point(OP_PREDICT, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0));
      send_item(point(OP_ADD, 32'h000F_F000, 32'h000F_F000, 32'h000F_F000, 32'hFFFF_0000));
      send_item(point(OP_PREDICT, 32'h000F_F000, 32'h000F_F000, 32'h000F_F000, 32'h0));
      // less than one bin below the lower bound still lands in bin 0
      send_item(point(OP_ADD, 32'hFFFF_8000, 32'h0002_0000, 32'h0003_0000, 32'h7FFF_FFFF));
      send_item(point(OP_PREDICT, 32'hFFFF_C000, 32'h0002_8000, 32'h0003_8000, 32'h0));
      send_item(point(OP_ADD, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_item(point(OP_PREDICT, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000, 32'h0));
      send_item(point(OP_ADD, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_item(point(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000));
      send_item(point(OP_ADD, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000));
      send_item(point(OP_PREDICT, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000, 32'h0));
      send_item(point(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(point(OP_PREDICT, 32'h0001_0000, 32'h0001_0000, 32'h0010_0000, 32'h0));
      send_item(point(OP_ADD_SUB, 32'h0004_8000, 32'h0004_8000, 32'h0004_8000, 32'h0001_0000));
      send_item(point(OP_PREDICT, 32'h0004_8000, 32'h0004_8000, 32'h0004_8000, 32'h0));
      wait_idle();
   endtask

   task automatic test_subdivide();
      idle_en = 1'b1;
      for (int lvl = 1; lvl <= 3; lvl++) begin
         wait_idle();
         write_reg(CSR_SUBDIV, 32'(lvl));
         send_item(point(OP_ADD_SUB, 32'h0008_8000, 32'h0008_8000, 32'h0008_8000,
                         32'h7FFF_FFFF));
         send_item(point(OP_ADD_SUB, 32'hFFFF_3333, 32'h0008_0000, 32'h0008_0000,
                         32'hFFFF_0000));
         send_item(point(OP_ADD_SUB, 32'h000F_E666, 32'h000F_E666, 32'h000F_E666,
                         32'h0001_0000));
         send_item(point(OP_PREDICT, 32'h0008_8000, 32'h0008_8000, 32'h0008_8000, 32'h0));
      end
      wait_idle();
   endtask

   task automatic test_large_weights();
      idle_en = 1'b0;
      configure(default_cfg());
      repeat (40)
         send_item(point(OP_ADD, 32'h0003_8000, 32'h0005_8000, 32'h0007_8000, 32'h7FFF_FFFF));
      send_item(point(OP_PREDICT, 32'h0003_8000, 32'h0005_8000, 32'h0007_8000, 32'h0));
      repeat (40)
         send_item(point(OP_ADD, 32'h0007_8000, 32'h0005_8000, 32'h0003_8000, 32'h8000_0000));
      send_item(point(OP_PREDICT, 32'h0007_8000, 32'h0005_8000, 32'h0003_8000, 32'h0));
      wait_idle();
   endtask

   task automatic test_backpressure();
      idle_en = 1'b0;
      hold_off = 400;
      repeat (24)
         send_item(random_item());
      wait_idle();
   endtask

   task automatic test_random_configs();
      req_type item, last_add;
      last_add = point(OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0);
      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         configure(phase_cfg(ph));
         idle_en = (ph != 3);
         for (int i = 0; i < 190; i++) begin
            item = random_item();
            // read back where the last add went
            if (item.opcode == OP_PREDICT && $urandom_range(0, 1)) begin
               item.coord_x = last_add.coord_x;
               item.coord_y = last_add.coord_y;
               item.coord_z = last_add.coord_z;
            end
            if (item.opcode == OP_ADD || item.opcode == OP_ADD_SUB)
               last_add = item;
            send_item(item);
         end
      end
      wait_idle();
   endtask

   initial begin : rsp_side
      int n;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            n = hold_off;
            hold_off = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (idle_en && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_payload);
            err_count++;
         end else begin
            want = due_rsp.pop_front();
            if (rsp_payload.accepted !== want.accepted) begin
               $display("%0t: accepted expected %0d actual %0d", $time,
                        want.accepted, rsp_payload.accepted);
               err_count++;
            end
            if (rsp_payload.landed_points !== want.landed_points) begin
               $display("%0t: landed_points expected %0d actual %0d", $time,
                        want.landed_points, rsp_payload.landed_points);
               err_count++;
            end
            if (rsp_payload.bin_value !== want.bin_value) begin
               $display("%0t: bin_value expected %0d actual %0d", $time,
                        want.bin_value, rsp_payload.bin_value);
               err_count++;
            end
            if (rsp_payload.total_count !== want.total_count) begin
               $display("%0t: total_count expected %0d actual %0d", $time,
                        want.total_count, rsp_payload.total_count);
               err_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      model_cfg = default_cfg();
      points_seen = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_grid();
      test_subdivide();
      test_large_weights();
      test_backpressure();
      test_random_configs();
      repeat (DRAIN) @(posedge clock);
      if (err_count == 0 && due_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
